@@ rtl/core/lbsi_pkg.sv @@
// ----------------------------------------------------------------------------
// lbsi_pkg: shared types and constants of the lattice block site indexer
// Holds field widths, status and register codes, and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package lbsi_pkg;

  localparam int MAX_EXTENT = 16;
  localparam int MAX_SITES  = 4096;
  localparam int IDX_W      = 13;
  localparam int ADDR_W     = 12;
  localparam int EXT_W      = 5;
  localparam int CRD_W      = 4;
  localparam int NBR        = 9;
  localparam int NBR_W      = 4;
  localparam int OUT_W      = 120;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_BUILT = 2'd1;
  localparam logic [1:0] ST_GEOM      = 2'd2;

  // item kinds
  localparam logic OP_BUILD  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_EXT_T = 2'd0;
  localparam logic [1:0] REG_EXT_X = 2'd1;
  localparam logic [1:0] REG_EXT_Y = 2'd2;
  localparam logic [1:0] REG_EXT_Z = 2'd3;

  // datapath operations
  localparam logic [2:0] DP_NOP    = 3'd0;
  localparam logic [2:0] DP_VOL1   = 3'd1;
  localparam logic [2:0] DP_VOL2   = 3'd2;
  localparam logic [2:0] DP_VOL3   = 3'd3;
  localparam logic [2:0] DP_COMMIT = 3'd4;
  localparam logic [2:0] DP_FAIL   = 3'd5;
  localparam logic [2:0] DP_WRITE  = 3'd6;
  localparam logic [2:0] DP_READ   = 3'd7;

  typedef struct packed {
    logic [2:0]       op;
    logic             load_coord;
    logic             clr_built;
    logic             set_built;
    logic [NBR_W-1:0] nbr;
    logic [CRD_W-1:0] wt;
    logic [CRD_W-1:0] wx;
    logic [CRD_W-1:0] wy;
    logic [CRD_W-1:0] wz;
    logic             out_load;
    logic             out_zero;
    logic [1:0]       out_status;
  } lbsi_cmd_t;

  typedef struct packed {
    logic [EXT_W-1:0] ext_t;
    logic [EXT_W-1:0] ext_x;
    logic [EXT_W-1:0] ext_y;
    logic [EXT_W-1:0] ext_z;
    logic [2:0]       cb_x;
    logic [2:0]       cb_y;
    logic [2:0]       cb_z;
    logic             geom_ok;
    logic             vol_zero;
    logic             built;
    logic             out_free;
  } lbsi_stat_t;

  function automatic logic div3(input logic [EXT_W-1:0] e);
    logic r;
    r = 1'b0;
    case (e)
      5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd15, 5'd18, 5'd21, 5'd24, 5'd27,
      5'd30: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] cache_ext(input logic [EXT_W-1:0] e);
    logic [2:0] r;
    if (e[1:0] == 2'b00) begin
      r = 3'd4;
    end else if (div3(e)) begin
      r = 3'd3;
    end else begin
      r = 3'd2;
    end
    return r;
  endfunction

endpackage

@@ rtl/core/lbsi_dp.sv @@
// ----------------------------------------------------------------------------
// lbsi_dp: datapath of the lattice block site indexer
// Extent registers, volume and stride products, the index table, a two-stage
// address pipe, neighbor result collection and the output register.
// ----------------------------------------------------------------------------
module lbsi_dp
  import lbsi_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  input  logic [1:0]          cfg_index,
  input  logic [EXT_W-1:0]    cfg_data,
  input  logic [4*CRD_W-1:0]  coord_in,
  input  lbsi_cmd_t           cmd,
  output lbsi_stat_t          stat,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [1:0]          out_status,
  output logic [OUT_W-1:0]    out_data
);

  logic [EXT_W-1:0]  ext_t_r, ext_x_r, ext_y_r, ext_z_r;
  logic [9:0]        s1_r;
  logic [14:0]       s0_r;
  logic [19:0]       vol_r;
  logic [IDX_W-1:0]  site_count_r;
  logic              built_r;
  logic [ADDR_W-1:0] ofs_e_r, ofs_o_r;
  logic [4*CRD_W-1:0] crd_r;

  logic [ADDR_W-1:0] pt_r, px_r, py_r, pz_r, wd_r;
  logic              s1_we_r, s1_rd_r, s1_out_r;
  logic              s2_rd_r, s2_out_r;
  logic [ADDR_W-1:0] mem_q_r;
  logic [ADDR_W-1:0] index_table [MAX_SITES];
  logic [ADDR_W-1:0] addr;

  logic [IDX_W-1:0]  res_r [NBR];
  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [OUT_W-1:0]  out_data_r;
  logic [OUT_W-1:0]  res_pack;

  logic [EXT_W-1:0]  pos_t, pos_x, pos_y, pos_z;
  logic              outside, par;

  // geometry check on the finished volume
  always_comb begin
    stat.ext_t    = ext_t_r;
    stat.ext_x    = ext_x_r;
    stat.ext_y    = ext_y_r;
    stat.ext_z    = ext_z_r;
    stat.cb_x     = cache_ext(ext_x_r);
    stat.cb_y     = cache_ext(ext_y_r);
    stat.cb_z     = cache_ext(ext_z_r);
    stat.vol_zero = (vol_r == '0);
    stat.built    = built_r;
    stat.out_free = !out_valid_r || out_ready;
    stat.geom_ok  = (ext_t_r <= EXT_W'(MAX_EXTENT)) && (ext_x_r <= EXT_W'(MAX_EXTENT)) &&
                    (ext_y_r <= EXT_W'(MAX_EXTENT)) && (ext_z_r <= EXT_W'(MAX_EXTENT)) &&
                    !vol_r[0] && (vol_r <= 20'(MAX_SITES)) &&
                    (stat.cb_x != 3'd2 || !ext_x_r[0]) &&
                    (stat.cb_y != 3'd2 || !ext_y_r[0]) &&
                    (stat.cb_z != 3'd2 || !ext_z_r[0]);
  end

  // site position: walk coordinates or a neighbor of the latched lookup site
  always_comb begin
    if (cmd.op == DP_WRITE) begin
      pos_t = {1'b0, cmd.wt};
      pos_x = {1'b0, cmd.wx};
      pos_y = {1'b0, cmd.wy};
      pos_z = {1'b0, cmd.wz};
    end else begin
      pos_t = {1'b0, crd_r[3:0]};
      pos_x = {1'b0, crd_r[7:4]};
      pos_y = {1'b0, crd_r[11:8]};
      pos_z = {1'b0, crd_r[15:12]};
      case (cmd.nbr)
        4'd1:    pos_t = pos_t + 5'd1;
        4'd2:    pos_t = pos_t - 5'd1;
        4'd3:    pos_x = pos_x + 5'd1;
        4'd4:    pos_x = pos_x - 5'd1;
        4'd5:    pos_y = pos_y + 5'd1;
        4'd6:    pos_y = pos_y - 5'd1;
        4'd7:    pos_z = pos_z + 5'd1;
        4'd8:    pos_z = pos_z - 5'd1;
        default: pos_t = pos_t;
      endcase
    end
    // a step below zero wraps to 31, which is beyond any accepted extent
    outside = (pos_t >= ext_t_r) || (pos_x >= ext_x_r) ||
              (pos_y >= ext_y_r) || (pos_z >= ext_z_r);
    par     = pos_t[0] ^ pos_x[0] ^ pos_y[0] ^ pos_z[0];
  end

  assign addr = pt_r + px_r + py_r + pz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_t_r      <= EXT_W'(4);
      ext_x_r      <= EXT_W'(4);
      ext_y_r      <= EXT_W'(4);
      ext_z_r      <= EXT_W'(4);
      built_r      <= 1'b0;
      site_count_r <= '0;
      s1_we_r      <= 1'b0;
      s1_rd_r      <= 1'b0;
      s2_rd_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_EXT_T: ext_t_r <= cfg_data;
          REG_EXT_X: ext_x_r <= cfg_data;
          REG_EXT_Y: ext_y_r <= cfg_data;
          REG_EXT_Z: ext_z_r <= cfg_data;
          default:   ext_t_r <= ext_t_r;
        endcase
        built_r <= 1'b0;
      end else if (cmd.clr_built) begin
        built_r <= 1'b0;
      end else if (cmd.set_built) begin
        built_r <= 1'b1;
      end
      if (cmd.op == DP_COMMIT) begin
        site_count_r <= vol_r[IDX_W-1:0];
      end else if (cmd.op == DP_FAIL) begin
        site_count_r <= '0;
      end
      s1_we_r <= (cmd.op == DP_WRITE);
      s1_rd_r <= (cmd.op == DP_READ);
      s2_rd_r <= s1_rd_r;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_coord) begin
      crd_r <= coord_in;
    end
    unique case (cmd.op)
      DP_VOL1: s1_r  <= 10'(ext_y_r * ext_z_r);
      DP_VOL2: s0_r  <= 15'(s1_r * ext_x_r);
      DP_VOL3: vol_r <= 20'(s0_r * ext_t_r);
      DP_COMMIT: begin
        ofs_e_r <= '0;
        ofs_o_r <= vol_r[ADDR_W:1];
      end
      DP_WRITE: begin
        if (par) begin
          wd_r    <= ofs_o_r;
          ofs_o_r <= ofs_o_r + ADDR_W'(1);
        end else begin
          wd_r    <= ofs_e_r;
          ofs_e_r <= ofs_e_r + ADDR_W'(1);
        end
      end
      default: wd_r <= wd_r;
    endcase
    pt_r     <= ADDR_W'(pos_t * s0_r);
    px_r     <= ADDR_W'(pos_x * s1_r);
    py_r     <= ADDR_W'(pos_y * ext_z_r);
    pz_r     <= ADDR_W'(pos_z);
    s1_out_r <= outside;
    s2_out_r <= s1_out_r;
    if (s2_rd_r) begin
      for (int k = 0; k < NBR - 1; k++) begin
        res_r[k] <= res_r[k+1];
      end
      res_r[NBR-1] <= s2_out_r ? site_count_r : {1'b0, mem_q_r};
    end
    if (cmd.out_load) begin
      out_status_r <= cmd.out_status;
      out_data_r   <= cmd.out_zero ? '0 : res_pack;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_we_r) begin
      index_table[addr] <= wd_r;
    end
    if (s1_rd_r) begin
      mem_q_r <= index_table[addr];
    end
  end

  always_comb begin
    res_pack = '0;
    for (int k = 0; k < NBR; k++) begin
      res_pack[k*IDX_W +: IDX_W] = res_r[k];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_data   = out_data_r;

endmodule

@@ rtl/core/lbsi_ctrl.sv @@
// ----------------------------------------------------------------------------
// lbsi_ctrl: controller of the lattice block site indexer
// Sequences the volume products, the cache-block walk of a build and the
// nine table reads of a lookup, then hands the result to the output register.
// ----------------------------------------------------------------------------
module lbsi_ctrl
  import lbsi_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_op,
  output logic       in_ready,
  input  lbsi_stat_t stat,
  output lbsi_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_VOL1  = 4'd1;
  localparam logic [3:0] S_VOL2  = 4'd2;
  localparam logic [3:0] S_VOL3  = 4'd3;
  localparam logic [3:0] S_CHECK = 4'd4;
  localparam logic [3:0] S_WALK  = 4'd5;
  localparam logic [3:0] S_LOOK  = 4'd6;
  localparam logic [3:0] S_DRAIN = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0]       state_r, state_nxt;
  logic [CRD_W-1:0] a0_r, a1_r, a2_r, a3_r, b1_r, b2_r, b3_r;
  logic [CRD_W-1:0] a0_nxt, a1_nxt, a2_nxt, a3_nxt, b1_nxt, b2_nxt, b3_nxt;
  logic [NBR_W-1:0] nbr_r, nbr_nxt;
  logic             drain_r, drain_nxt;
  logic [1:0]       st_r, st_nxt;
  logic             zero_r, zero_nxt;
  logic             w3, w2, w1, w0, wb3, wb2, wb1;

  // wrap flags of the walk counters, innermost first
  always_comb begin
    w3  = ({1'b0, a3_r} + 5'd1) == {2'b0, stat.cb_z};
    w2  = ({1'b0, a2_r} + 5'd1) == {2'b0, stat.cb_y};
    w1  = ({1'b0, a1_r} + 5'd1) == {2'b0, stat.cb_x};
    w0  = ({1'b0, a0_r} + 5'd1) == stat.ext_t;
    wb3 = ({1'b0, b3_r} + {2'b0, stat.cb_z}) == stat.ext_z;
    wb2 = ({1'b0, b2_r} + {2'b0, stat.cb_y}) == stat.ext_y;
    wb1 = ({1'b0, b1_r} + {2'b0, stat.cb_x}) == stat.ext_x;
  end

  always_comb begin
    state_nxt = state_r;
    a0_nxt = a0_r; a1_nxt = a1_r; a2_nxt = a2_r; a3_nxt = a3_r;
    b1_nxt = b1_r; b2_nxt = b2_r; b3_nxt = b3_r;
    nbr_nxt   = nbr_r;
    drain_nxt = drain_r;
    st_nxt    = st_r;
    zero_nxt  = zero_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.wt    = a0_r;
    cmd.wx    = b1_r + a1_r;
    cmd.wy    = b2_r + a2_r;
    cmd.wz    = b3_r + a3_r;
    cmd.nbr   = nbr_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == OP_BUILD) begin
            cmd.clr_built = 1'b1;
            state_nxt     = S_VOL1;
          end else if (stat.built) begin
            cmd.load_coord = 1'b1;
            nbr_nxt   = '0;
            st_nxt    = ST_OK;
            zero_nxt  = 1'b0;
            state_nxt = S_LOOK;
          end else begin
            st_nxt    = ST_NOT_BUILT;
            zero_nxt  = 1'b1;
            state_nxt = S_DONE;
          end
        end
      end
      S_VOL1: begin
        cmd.op    = DP_VOL1;
        state_nxt = S_VOL2;
      end
      S_VOL2: begin
        cmd.op    = DP_VOL2;
        state_nxt = S_VOL3;
      end
      S_VOL3: begin
        cmd.op    = DP_VOL3;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        zero_nxt = 1'b1;
        a0_nxt = '0; a1_nxt = '0; a2_nxt = '0; a3_nxt = '0;
        b1_nxt = '0; b2_nxt = '0; b3_nxt = '0;
        if (stat.geom_ok) begin
          cmd.op        = DP_COMMIT;
          cmd.set_built = 1'b1;
          st_nxt        = ST_OK;
          state_nxt     = stat.vol_zero ? S_DONE : S_WALK;
        end else begin
          cmd.op    = DP_FAIL;
          st_nxt    = ST_GEOM;
          state_nxt = S_DONE;
        end
      end
      S_WALK: begin
        cmd.op = DP_WRITE;
        // advance the odometer: sites inside a cache block, then blocks
        a3_nxt = w3 ? '0 : a3_r + CRD_W'(1);
        if (w3) begin
          a2_nxt = w2 ? '0 : a2_r + CRD_W'(1);
          if (w2) begin
            a1_nxt = w1 ? '0 : a1_r + CRD_W'(1);
            if (w1) begin
              a0_nxt = w0 ? '0 : a0_r + CRD_W'(1);
              if (w0) begin
                b3_nxt = wb3 ? '0 : b3_r + CRD_W'(stat.cb_z);
                if (wb3) begin
                  b2_nxt = wb2 ? '0 : b2_r + CRD_W'(stat.cb_y);
                  if (wb2) begin
                    b1_nxt = wb1 ? '0 : b1_r + CRD_W'(stat.cb_x);
                    if (wb1) begin
                      drain_nxt = 1'b0;
                      state_nxt = S_DRAIN;
                    end
                  end
                end
              end
            end
          end
        end
      end
      S_LOOK: begin
        cmd.op = DP_READ;
        if (nbr_r == NBR_W'(NBR - 1)) begin
          drain_nxt = 1'b0;
          state_nxt = S_DRAIN;
        end else begin
          nbr_nxt = nbr_r + NBR_W'(1);
        end
      end
      S_DRAIN: begin
        drain_nxt = 1'b1;
        if (drain_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_zero   = zero_r;
          cmd.out_status = st_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      drain_r <= 1'b0;
      nbr_r   <= '0;
      st_r    <= ST_OK;
      zero_r  <= 1'b1;
      a0_r <= '0; a1_r <= '0; a2_r <= '0; a3_r <= '0;
      b1_r <= '0; b2_r <= '0; b3_r <= '0;
    end else begin
      state_r <= state_nxt;
      drain_r <= drain_nxt;
      nbr_r   <= nbr_nxt;
      st_r    <= st_nxt;
      zero_r  <= zero_nxt;
      a0_r <= a0_nxt; a1_r <= a1_nxt; a2_r <= a2_nxt; a3_r <= a3_nxt;
      b1_r <= b1_nxt; b2_r <= b2_nxt; b3_r <= b3_nxt;
    end
  end

endmodule

@@ rtl/core/lattice_block_site_indexer_core.sv @@
// Build: volume products and checks (VOL1, VOL2, VOL3, CHECK), then one site
//   written per cycle on one table write port, then drain and delivery.
// Lookup: 9 table reads on one read port, then drain and delivery. No new
//   item is taken meanwhile; a lookup before a build answers not built.
// Reset: extents return to 4, table marked not built, output empty;
//   table contents stay undefined until a build writes them.
// ----------------------------------------------------------------------------
// lattice_block_site_indexer_core: even-odd site ordering of a 4D block
// Builds the site index table in cache-block order and answers site and
// neighbor index lookups.
// ----------------------------------------------------------------------------
module lattice_block_site_indexer_core
  import lbsi_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [4*CRD_W-1:0]  in_tdata,   // coord_t, coord_x, coord_y, coord_z
  input  logic                in_tuser,   // op
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OUT_W-1:0]    out_tdata,  // site_index, up_t, dn_t, up_x, dn_x,
                                          // up_y, dn_y, up_z, dn_z, zero pad
  output logic [1:0]          out_tuser,  // status
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [EXT_W-1:0]    cfg_data
);

  lbsi_cmd_t  cmd;
  lbsi_stat_t stat;

  assign cfg_ready = 1'b1;

  lbsi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_op    (in_tuser),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lbsi_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .coord_in   (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_status (out_tuser),
    .out_data   (out_tdata)
  );

endmodule

@@ rtl/core/lbsi_chk.sv @@
// ----------------------------------------------------------------------------
// lbsi_chk: port checker of the lattice block site indexer
// Watches the top-level ports for output hold, status range, empty payloads
// on error results, one item at a time and a configuration port that never stalls.
// ----------------------------------------------------------------------------
module lbsi_chk
  import lbsi_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_tvalid,
  input logic               in_tready,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [OUT_W-1:0]   out_tdata,
  input logic [1:0]         out_tuser,
  input logic               cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result transaction dropped while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_OK || out_tuser == ST_NOT_BUILT ||
                    out_tuser == ST_GEOM))
    else $error("status code out of range");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tdata == '0)
    else $error("error result carries index data");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken before the first finished");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration port stalled");

endmodule

bind lattice_block_site_indexer_core lbsi_chk u_lbsi_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_ready  (cfg_ready)
);
